// File: rtl/tdtm_pkg.sv
// ----------------------------------------------------------------------------
// tdtm_pkg
// Shared types and constants for the trimmed-mean filter over time-of-flight
// differences.
// ----------------------------------------------------------------------------
package tdtm_pkg;

  localparam int DATA_W     = 32;
  localparam int SAMPLES    = 8;
  localparam int TRIM       = 2;
  localparam int MEAN_SHIFT = 2;
  localparam int CNT_W      = $clog2(SAMPLES);

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam cnt_t LAST_IDX  = cnt_t'(SAMPLES - 1);
  localparam cnt_t LAST_PASS = cnt_t'(SAMPLES - 2);
  localparam cnt_t SUM_FIRST = cnt_t'(TRIM);
  localparam cnt_t SUM_LAST  = cnt_t'(SAMPLES - TRIM - 1);

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [1:0] {
    LINE_HOLD,
    LINE_SHIFT_IN,
    LINE_BUBBLE,
    LINE_ROTATE
  } line_op_t;

  typedef struct packed {
    line_op_t op;
    logic     keep_head;
  } line_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NEG,
    ST_SORT,
    ST_SUM
  } state_t;

endpackage

// File: rtl/tof_diff_trimmed_mean.sv
// ----------------------------------------------------------------------------
// tof_diff_trimmed_mean
// Trimmed mean of eight absolute time-of-flight differences.
//
// A request (up_time, down_time) is taken at a rising edge where start is
// high and busy is low. When up_time >= down_time the absolute difference
// goes into the line at once; otherwise the pair is registered and ST_NEG
// subtracts the other way round. Both use the one shared add/subtract
// unit; busy is high in ST_NEG. The eighth request of a group starts a
// bubble sort on the register line: 7 passes, each of seven compares at
// the head and one rotate, then a summing phase that adds the middle four
// values through the same unit. The result appears on mean_diff with done
// high for exactly one cycle as busy falls. The receiver cannot stall; a
// new request may be taken in the cycle that done is high.
// Reset clears the sequencer, the pair count and done; the difference line
// needs no clearing since it is fully written before it is read.
// ----------------------------------------------------------------------------
module tof_diff_trimmed_mean (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [31:0]           up_time,
  input  logic [31:0]           down_time,
  output logic                  done,
  output logic [31:0]           mean_diff
);

  tdtm_pkg::state_t     state, state_next;
  tdtm_pkg::cnt_t       pair_count, pair_count_next;
  tdtm_pkg::cnt_t       pass, pass_next;
  tdtm_pkg::cnt_t       step, step_next;
  tdtm_pkg::word_t      acc, acc_next;
  tdtm_pkg::word_t      up_r, down_r;
  logic                 load_pair;
  logic                 done_next;
  tdtm_pkg::word_t      mean_next;

  tdtm_pkg::alu_op_t    alu_op;
  tdtm_pkg::word_t      alu_a, alu_b, alu_res;
  logic                 alu_borrow;

  tdtm_pkg::line_ctrl_t line_ctrl;
  tdtm_pkg::word_t      line_head, line_second;

  tdtm_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  tdtm_line u_line (
    .clk    (clk),
    .ctrl   (line_ctrl),
    .din    (alu_res),
    .head   (line_head),
    .second (line_second)
  );

  assign busy = (state != tdtm_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tdtm_pkg::ST_IDLE;
      pair_count <= '0;
      pass       <= '0;
      step       <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      pair_count <= pair_count_next;
      pass       <= pass_next;
      step       <= step_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
    if (load_pair) begin
      up_r   <= up_time;
      down_r <= down_time;
    end
    if (done_next) begin
      mean_diff <= mean_next;
    end
  end

  always_comb begin
    state_next      = state;
    pair_count_next = pair_count;
    pass_next       = pass;
    step_next       = step;
    acc_next        = acc;
    load_pair       = 1'b0;
    done_next       = 1'b0;
    mean_next       = alu_res >> tdtm_pkg::MEAN_SHIFT;
    alu_op          = tdtm_pkg::ALU_SUB;
    alu_a           = up_time;
    alu_b           = down_time;
    line_ctrl       = '{op: tdtm_pkg::LINE_HOLD, keep_head: 1'b0};

    case (state)
      tdtm_pkg::ST_IDLE: begin
        if (start) begin
          if (alu_borrow) begin
            load_pair  = 1'b1;
            state_next = tdtm_pkg::ST_NEG;
          end else begin
            line_ctrl.op = tdtm_pkg::LINE_SHIFT_IN;
            if (pair_count == tdtm_pkg::LAST_IDX) begin
              pair_count_next = '0;
              pass_next       = '0;
              step_next       = '0;
              state_next      = tdtm_pkg::ST_SORT;
            end else begin
              pair_count_next = pair_count + 1'b1;
            end
          end
        end
      end

      tdtm_pkg::ST_NEG: begin
        alu_a        = down_r;
        alu_b        = up_r;
        line_ctrl.op = tdtm_pkg::LINE_SHIFT_IN;
        if (pair_count == tdtm_pkg::LAST_IDX) begin
          pair_count_next = '0;
          pass_next       = '0;
          step_next       = '0;
          state_next      = tdtm_pkg::ST_SORT;
        end else begin
          pair_count_next = pair_count + 1'b1;
          state_next      = tdtm_pkg::ST_IDLE;
        end
      end

      // A borrow on second - head means the head is the larger one.
      tdtm_pkg::ST_SORT: begin
        alu_a               = line_second;
        alu_b               = line_head;
        line_ctrl.keep_head = alu_borrow;
        step_next           = step + 1'b1;
        if (step == tdtm_pkg::LAST_IDX) begin
          line_ctrl.op = tdtm_pkg::LINE_ROTATE;
          step_next    = '0;
          if (pass == tdtm_pkg::LAST_PASS) begin
            acc_next   = '0;
            state_next = tdtm_pkg::ST_SUM;
          end else begin
            pass_next = pass + 1'b1;
          end
        end else begin
          line_ctrl.op = tdtm_pkg::LINE_BUBBLE;
        end
      end

      // The line is now ascending; rotate it and add the heads at the
      // middle ranks.
      tdtm_pkg::ST_SUM: begin
        alu_op       = tdtm_pkg::ALU_ADD;
        alu_a        = acc;
        alu_b        = line_head;
        line_ctrl.op = tdtm_pkg::LINE_ROTATE;
        step_next    = step + 1'b1;
        if (step >= tdtm_pkg::SUM_FIRST) begin
          acc_next = alu_res;
        end
        if (step == tdtm_pkg::SUM_LAST) begin
          done_next  = 1'b1;
          step_next  = '0;
          state_next = tdtm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = tdtm_pkg::ST_IDLE;
      end
    endcase
  end

  // A result only ever comes out of the last summing step.
  a_done_from_sum: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == tdtm_pkg::ST_SUM)
    else $error("done raised outside the summing phase");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_last_pair_sorts: assert property (@(posedge clk) disable iff (rst)
    (state == tdtm_pkg::ST_IDLE && start && !alu_borrow &&
     pair_count == tdtm_pkg::LAST_IDX) |=> state == tdtm_pkg::ST_SORT)
    else $error("eighth pair did not start the sort");

  a_pass_bound: assert property (@(posedge clk) disable iff (rst)
    state == tdtm_pkg::ST_SORT |-> pass <= tdtm_pkg::LAST_PASS)
    else $error("sort pass count overran");

  a_count_idle_sum: assert property (@(posedge clk) disable iff (rst)
    (state == tdtm_pkg::ST_SORT || state == tdtm_pkg::ST_SUM) |-> pair_count == '0)
    else $error("pair count not cleared during the group computation");

endmodule

// File: rtl/tdtm_alu.sv
// ----------------------------------------------------------------------------
// tdtm_alu
// Shared 32-bit add/subtract unit. The borrow output doubles as the
// less-than flag for the sort compares.
// ----------------------------------------------------------------------------
module tdtm_alu (
  input  tdtm_pkg::alu_op_t op,
  input  tdtm_pkg::word_t   a,
  input  tdtm_pkg::word_t   b,
  output tdtm_pkg::word_t   res,
  output logic              borrow
);

  logic [tdtm_pkg::DATA_W:0] wide;

  always_comb begin
    case (op)
      tdtm_pkg::ALU_ADD: wide = {1'b0, a} + {1'b0, b};
      tdtm_pkg::ALU_SUB: wide = {1'b0, a} - {1'b0, b};
      default:           wide = '0;
    endcase
  end

  assign res    = wide[tdtm_pkg::DATA_W-1:0];
  assign borrow = (op == tdtm_pkg::ALU_SUB) && wide[tdtm_pkg::DATA_W];

endmodule

// File: rtl/tdtm_line.sv
// ----------------------------------------------------------------------------
// tdtm_line
// Eight-entry register line holding the differences of one group. New
// differences shift in at the tail; the sort works by rotating the line
// past a fixed compare point at the head.
// ----------------------------------------------------------------------------
module tdtm_line (
  input  logic                 clk,
  input  tdtm_pkg::line_ctrl_t ctrl,
  input  tdtm_pkg::word_t      din,
  output tdtm_pkg::word_t      head,
  output tdtm_pkg::word_t      second
);

  tdtm_pkg::word_t v [tdtm_pkg::SAMPLES];

  assign head   = v[0];
  assign second = v[1];

  always_ff @(posedge clk) begin
    case (ctrl.op)
      tdtm_pkg::LINE_SHIFT_IN: begin
        for (int i = 0; i < tdtm_pkg::SAMPLES - 1; i++) v[i] <= v[i+1];
        v[tdtm_pkg::SAMPLES-1] <= din;
      end
      // The larger of the first two stays at the head as the carry; the
      // smaller drops to the tail.
      tdtm_pkg::LINE_BUBBLE: begin
        v[0] <= ctrl.keep_head ? v[0] : v[1];
        for (int i = 1; i < tdtm_pkg::SAMPLES - 1; i++) v[i] <= v[i+1];
        v[tdtm_pkg::SAMPLES-1] <= ctrl.keep_head ? v[1] : v[0];
      end
      tdtm_pkg::LINE_ROTATE: begin
        for (int i = 0; i < tdtm_pkg::SAMPLES - 1; i++) v[i] <= v[i+1];
        v[tdtm_pkg::SAMPLES-1] <= v[0];
      end
      default: begin
      end
    endcase
  end

endmodule

// File: tb/sv/tof_diff_trimmed_mean_tb.sv
// ----------------------------------------------------------------------------
// tof_diff_trimmed_mean_tb
// Drives pairs of time-of-flight readings into the trimmed-mean filter and
// checks every mean against a scoreboard that keeps its own eight-entry
// difference line. A directed part covers extreme readings, equal readings,
// a wrapping sum and tied differences. A long random part with random sender
// gaps follows.
// ----------------------------------------------------------------------------
module tof_diff_trimmed_mean_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PAIRS = 880;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 80;

  class mean_scoreboard;
    tdtm_pkg::word_t gap_line[tdtm_pkg::SAMPLES];
    int unsigned     pairs_in_group;
    tdtm_pkg::word_t exp_means[$];
    int unsigned     mismatches;

    function new();
      pairs_in_group = 0;
      mismatches     = 0;
    endfunction

    function tdtm_pkg::word_t trimmed_mean_of_group();
      tdtm_pkg::word_t v[tdtm_pkg::SAMPLES];
      tdtm_pkg::word_t key;
      tdtm_pkg::word_t sum;
      int              j;
      v = gap_line;
      for (int i = 1; i < tdtm_pkg::SAMPLES; i++) begin
        key = v[i];
        j = i - 1;
        while (j >= 0 && v[j] > key) begin
          v[j + 1] = v[j];
          j--;
        end
        v[j + 1] = key;
      end
      // The sum keeps only its low 32 bits before the shift.
      sum = '0;
      for (int i = tdtm_pkg::TRIM; i < tdtm_pkg::SAMPLES - tdtm_pkg::TRIM; i++) begin
        sum = sum + v[i];
      end
      return sum >> tdtm_pkg::MEAN_SHIFT;
    endfunction

    function void note_request(tdtm_pkg::word_t up, tdtm_pkg::word_t down);
      gap_line[pairs_in_group] = (up >= down) ? up - down : down - up;
      pairs_in_group = (pairs_in_group + 1) % tdtm_pkg::SAMPLES;
      if (pairs_in_group == 0) begin
        exp_means.push_back(trimmed_mean_of_group());
      end
    endfunction

    function void check_mean(tdtm_pkg::word_t actual);
      tdtm_pkg::word_t want;
      if (exp_means.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mean_diff %h arrived with no mean pending", actual);
        end
        return;
      end
      want = exp_means.pop_front();
      if (actual !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mean_diff mismatch: expected %h, got %h", want, actual);
        end
      end
    endfunction
  endclass

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            start     = 1'b0;
  tdtm_pkg::word_t up_time   = '0;
  tdtm_pkg::word_t down_time = '0;
  logic            busy;
  logic            done;
  tdtm_pkg::word_t mean_diff;

  mean_scoreboard sb = new();
  int unsigned    quiet_cycles = 0;

  tdtm_pkg::word_t dir_up[24] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
    32'h0000_0001, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
    32'hFFFF_FFFF, 32'hC000_0000, 32'h0000_0000, 32'hE000_0000,
    32'hFFFF_FFF0, 32'h0000_0003, 32'hAAAA_AAAA, 32'h0000_0000,
    32'h0000_0100, 32'h0000_0105, 32'h0000_0005, 32'h0000_0000,
    32'hFFFF_FFFA, 32'hFFFF_FFFF, 32'h1234_5678, 32'h1234_567D
  };
  tdtm_pkg::word_t dir_down[24] = '{
    32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h0000_0000, 32'h0000_0000, 32'hD000_0000, 32'h1000_0000,
    32'h0000_0005, 32'hF000_0003, 32'h0000_0000, 32'h5555_5555,
    32'h0000_0105, 32'h0000_0100, 32'h0000_0000, 32'h0000_0005,
    32'hFFFF_FFFF, 32'hFFFF_FFFA, 32'h1234_567D, 32'h1234_5678
  };

  tof_diff_trimmed_mean dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .up_time   (up_time),
    .down_time (down_time),
    .done      (done),
    .mean_diff (mean_diff)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Requests and results are sampled here, before this edge's updates land.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        sb.note_request(up_time, down_time);
      end
      if (done) begin
        sb.check_mean(mean_diff);
      end
      if ((start && !busy) || done) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_request(input tdtm_pkg::word_t up, input tdtm_pkg::word_t down);
    start     <= 1'b1;
    up_time   <= up;
    down_time <= down;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.exp_means.size() != 0) @(posedge clk);
  endtask

  task automatic random_pair(output tdtm_pkg::word_t up, output tdtm_pkg::word_t down);
    tdtm_pkg::word_t gap;
    up   = $urandom;
    down = $urandom;
    case ($urandom_range(9))
      4, 5, 6: begin
        // Realistic readings: the two directions differ by a little.
        gap  = $urandom_range(4095);
        down = $urandom_range(1) ? up + gap : up - gap;
      end
      7: down = up;
      8: begin
        up   = up | 32'hC000_0000;
        down = down & 32'h0FFF_FFFF;
        if ($urandom_range(1)) begin
          gap  = up;
          up   = down;
          down = gap;
        end
      end
      9: begin
        up   = $urandom_range(1) ? '1 : '0;
        down = $urandom_range(1) ? '1 : '0;
      end
      default: ;
    endcase
  endtask

  initial begin
    tdtm_pkg::word_t u;
    tdtm_pkg::word_t d;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 24; i++) begin
      if (i % 5 == 3) begin
        idle_cycles($urandom_range(1, 3));
      end
      send_request(dir_up[i], dir_down[i]);
    end
    wait_drained();

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n == RANDOM_PAIRS / 2) begin
        wait_drained();
      end
      // Pairs 300 to 559 go back to back with no sender gaps.
      if (!(n >= 300 && n < 560) && $urandom_range(99) < 27) begin
        idle_cycles(($urandom_range(9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 4));
      end
      random_pair(u, d);
      send_request(u, d);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.exp_means.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
